// ===== rtl/salct_pkg.sv =====
// Shared types and constants for the set-associative LRU cache tag engine.
// No dependencies; imported by salct_ctrl, salct_dpath and the top level.
`timescale 1ns / 1ps
package salct_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_SETS_DEF  = 64;
  localparam int unsigned WAYS_DEF      = 4;
  localparam int unsigned ADDR_BITS_DEF = 32;

  // Access opcodes; the last one is unused and changes nothing
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLOCK_SHIFT    = 2'd0;
  localparam logic [1:0] CFG_WRITE_BACK     = 2'd1;
  localparam logic [1:0] CFG_WRITE_ALLOCATE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;   // capture an input transfer
    logic rd_en;      // read the tag and state rows of the set
    logic eval_fire;  // resolve the access, update the set, load the result
    logic clr_en;     // clear one set's state row
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // the clearing pass is on its last set
  } status_t;

endpackage

// ===== rtl/salct_ctrl.sv =====
// Sequencer of the cache tag engine: clearing pass, lookup steps, result handshake.
// Depends on salct_pkg.
`timescale 1ns / 1ps
module salct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  salct_pkg::status_t status_i,
  output salct_pkg::cmd_t    cmd_o
);
  import salct_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fire;

  assign fire       = (state_q == S_EVAL) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Drive the datapath commands
  always_comb begin
    cmd_o.latch_in  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd_en     = (state_q == S_READ);
    cmd_o.eval_fire = fire;
    cmd_o.clr_en    = (state_q == S_CLEAR);
  end

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (status_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_EVAL;
      S_EVAL:  if (fire) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (fire) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/salct_dpath.sv =====
// Datapath of the cache tag engine: configuration, tag and state memories,
// way compare, LRU update, counters and result register. Depends on salct_pkg.
`timescale 1ns / 1ps
module salct_dpath #(
  parameter int unsigned NUM_SETS  = salct_pkg::NUM_SETS_DEF,
  parameter int unsigned WAYS      = salct_pkg::WAYS_DEF,
  parameter int unsigned ADDR_BITS = salct_pkg::ADDR_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  salct_pkg::cmd_t    cmd_i,
  output salct_pkg::status_t status_o,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i,
  input  logic [1:0]         opcode_i,
  input  logic [31:0]        address_i,
  input  logic               mark_dirty_i,
  output logic               hit_o,
  output logic               evict_valid_o,
  output logic               evict_dirty_o,
  output logic [31:0]        evict_block_o,
  output logic [31:0]        read_hit_count_o,
  output logic [31:0]        write_hit_count_o,
  output logic [31:0]        read_miss_count_o,
  output logic [31:0]        write_miss_count_o,
  output logic [31:0]        writeback_count_o
);
  import salct_pkg::*;

  localparam int unsigned SET_W  = $clog2(NUM_SETS);
  localparam int unsigned SIDX_W = (SET_W > 0) ? SET_W : 1;
  localparam int unsigned TAG_W  = 32 - SET_W;
  localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned META_W = RANK_W + 2;
  localparam logic [31:0] AMASK  = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                   : 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(WAYS - 1);
  localparam logic [SIDX_W-1:0] SET_LAST    = SIDX_W'(NUM_SETS - 1);

  // Configuration registers
  logic [3:0] block_shift_q;
  logic       write_back_q, write_allocate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_shift_q    <= 4'd6;
      write_back_q     <= 1'b1;
      write_allocate_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLOCK_SHIFT:    block_shift_q    <= cfg_data_i;
        CFG_WRITE_BACK:     write_back_q     <= cfg_data_i[0];
        CFG_WRITE_ALLOCATE: write_allocate_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Split the address on capture
  logic [31:0]       block;
  logic [1:0]        op_q;
  logic              md_q;
  logic [SIDX_W-1:0] set_q;
  logic [TAG_W-1:0]  tag_q;

  assign block = (address_i & AMASK) >> block_shift_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= opcode_i;
      md_q  <= mark_dirty_i;
      set_q <= (SET_W > 0) ? block[SIDX_W-1:0] : '0;
      tag_q <= TAG_W'(block >> SET_W);
    end
  end

  // Clearing pass over the state rows after reset
  logic [SIDX_W-1:0] clr_q;

  assign status_o.clr_last = (clr_q == SET_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_en) clr_q <= clr_q + 1'b1;
  end

  // Tag and state memories, one row per set
  logic [WAYS*TAG_W-1:0]  tag_mem  [NUM_SETS];
  logic [WAYS*META_W-1:0] meta_mem [NUM_SETS];
  logic [WAYS*TAG_W-1:0]  tag_rd_q, tag_wd;
  logic [WAYS*META_W-1:0] meta_rd_q, meta_wd;
  logic                   tag_we, upd_we, meta_we;
  logic [SIDX_W-1:0]      meta_wa;

  assign meta_we = cmd_i.clr_en || upd_we;
  assign meta_wa = cmd_i.clr_en ? clr_q : set_q;

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[set_q] <= tag_wd;
    if (meta_we) meta_mem[meta_wa] <= cmd_i.clr_en ? '0 : meta_wd;
    if (cmd_i.rd_en) begin
      tag_rd_q  <= tag_mem[set_q];
      meta_rd_q <= meta_mem[set_q];
    end
  end

  // Resolve the access against the ways of the set
  logic [WAYS-1:0]   v, d, match;
  logic [RANK_W-1:0] rank [WAYS];
  logic [TAG_W-1:0]  tags [WAYS];
  logic              any_hit, any_inv, alloc, do_evict, active;
  logic [RANK_W-1:0] hw, iw, lw, tw;
  logic [RANK_W-1:0] old_rank;
  logic              age_all;
  logic              new_dirty, ev_dirty;
  logic [31:0]       ev_block;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      v[w]    = meta_rd_q[w*META_W + RANK_W + 1];
      d[w]    = meta_rd_q[w*META_W + RANK_W];
      rank[w] = meta_rd_q[w*META_W +: RANK_W];
      tags[w] = tag_rd_q[w*TAG_W +: TAG_W];
      match[w] = v[w] && (tags[w] == tag_q);
    end
    any_hit = |match;
    any_inv = ~&v;
    // Lowest matching way, lowest invalid way, oldest way
    hw = '0;
    iw = '0;
    lw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hw = RANK_W'(w);
      if (!v[w]) iw = RANK_W'(w);
      if (rank[w] == RANK_OLDEST) lw = RANK_W'(w);
    end
    active   = (op_q != OP_NONE);
    alloc    = active && !any_hit && !((op_q == OP_WRITE) && !write_allocate_q);
    do_evict = alloc && !any_inv;
    tw       = any_hit ? hw : (any_inv ? iw : lw);
    old_rank = rank[tw];
    age_all  = alloc && any_inv;

    // Dirty state of the target line
    if (any_hit) begin
      new_dirty = d[tw];
      if (op_q == OP_WRITE && write_back_q) new_dirty = 1'b1;
      if (op_q == OP_FILL && md_q && write_back_q) new_dirty = 1'b1;
    end else if (op_q == OP_WRITE) begin
      new_dirty = write_back_q;
    end else if (op_q == OP_FILL) begin
      new_dirty = md_q && write_back_q;
    end else begin
      new_dirty = 1'b0;
    end

    // New row: target newest; younger valid ways age, all on a free-way alloc
    meta_wd = meta_rd_q;
    tag_wd  = tag_rd_q;
    for (int w = 0; w < WAYS; w++) begin
      if (RANK_W'(w) == tw) begin
        meta_wd[w*META_W +: META_W] = {1'b1, new_dirty, {RANK_W{1'b0}}};
        if (alloc) tag_wd[w*TAG_W +: TAG_W] = tag_q;
      end else if (v[w] && (age_all || rank[w] < old_rank)) begin
        meta_wd[w*META_W +: RANK_W] = rank[w] + 1'b1;
      end
    end

    ev_dirty = do_evict && d[tw] && write_back_q;
    ev_block = (32'(tags[tw]) << SET_W) | 32'(set_q & SIDX_W'(NUM_SETS - 1));
  end

  assign upd_we = cmd_i.eval_fire && (any_hit ? active : alloc);
  assign tag_we = cmd_i.eval_fire && alloc;

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_hit_count_o   <= '0;
      write_hit_count_o  <= '0;
      read_miss_count_o  <= '0;
      write_miss_count_o <= '0;
      writeback_count_o  <= '0;
    end else if (cmd_i.eval_fire && active) begin
      if (op_q == OP_READ && any_hit) read_hit_count_o <= read_hit_count_o + 1'b1;
      if (op_q == OP_WRITE && any_hit) write_hit_count_o <= write_hit_count_o + 1'b1;
      if (op_q == OP_READ && !any_hit) read_miss_count_o <= read_miss_count_o + 1'b1;
      if (op_q == OP_WRITE && !any_hit) write_miss_count_o <= write_miss_count_o + 1'b1;
      if (ev_dirty) writeback_count_o <= writeback_count_o + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_fire) begin
      hit_o         <= active && any_hit;
      evict_valid_o <= do_evict;
      evict_dirty_o <= ev_dirty;
      evict_block_o <= do_evict ? ev_block : '0;
    end
  end

endmodule

// ===== rtl/set_assoc_lru_cache_tags_top.sv =====
// Top level of the set-associative LRU cache tag engine.
// Depends on salct_pkg, salct_ctrl and salct_dpath.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries opcode, byte address and
//   mark_dirty. Output channel (out_valid_o/out_ready_i) returns one result
//   per item: hit, eviction report and the five wrapping counters.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes block_shift,
//   write_back and write_allocate by index; it is always ready.
//   Steps: the input transfer is captured, the set's rows are read from the
//   tag and state memories, then way compare, LRU update and the result
//   register load follow. One item is in work at a time: a new input is
//   taken only once the last one has reached the result register.
//   Reset: a clearing pass clears the valid, dirty and LRU row of every set
//   in turn; no input is taken meanwhile, configuration writes are.
//   Stall: while a result waits, the next item is taken and looked up, and
//   it holds before its update until the waiting result is transferred.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags_top #(
  parameter int unsigned NUM_SETS  = salct_pkg::NUM_SETS_DEF,
  parameter int unsigned WAYS      = salct_pkg::WAYS_DEF,
  parameter int unsigned ADDR_BITS = salct_pkg::ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic        mark_dirty_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic        evict_valid_o,
  output logic        evict_dirty_o,
  output logic [31:0] evict_block_o,
  output logic [31:0] read_hit_count_o,
  output logic [31:0] write_hit_count_o,
  output logic [31:0] read_miss_count_o,
  output logic [31:0] write_miss_count_o,
  output logic [31:0] writeback_count_o
);
  import salct_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  salct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  salct_dpath #(
    .NUM_SETS  (NUM_SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .address_i          (address_i),
    .mark_dirty_i       (mark_dirty_i),
    .hit_o              (hit_o),
    .evict_valid_o      (evict_valid_o),
    .evict_dirty_o      (evict_dirty_o),
    .evict_block_o      (evict_block_o),
    .read_hit_count_o   (read_hit_count_o),
    .write_hit_count_o  (write_hit_count_o),
    .read_miss_count_o  (read_miss_count_o),
    .write_miss_count_o (write_miss_count_o),
    .writeback_count_o  (writeback_count_o)
  );

endmodule

// ===== rtl/salct_checker.sv =====
// Port-level checks for the cache tag engine, bound to its top level.
// Depends on set_assoc_lru_cache_tags_top.
`timescale 1ns / 1ps
module salct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic        evict_valid_o,
  input logic        evict_dirty_o,
  input logic [31:0] read_hit_count_o
);

  // One item in work at a time: no transfer straight after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // A waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(read_hit_count_o)))
    else $error("result dropped or changed while stalled");

  // A hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> !evict_valid_o)
    else $error("eviction reported on a hit");

  // A dirty report needs an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evict_dirty_o) |-> evict_valid_o)
    else $error("dirty report without eviction");

endmodule

bind set_assoc_lru_cache_tags_top salct_checker u_salct_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .hit_o            (hit_o),
  .evict_valid_o    (evict_valid_o),
  .evict_dirty_o    (evict_dirty_o),
  .read_hit_count_o (read_hit_count_o)
);
